// ----- rtl/core/sdbs_pkg.sv -----
// ============================================================================
// sdbs_pkg: shared types and constants for Sigma-Delta background subtraction
// Holds the frame geometry, the item and result records, the configuration
// record and the configuration register codes.
// ============================================================================
`default_nettype none

package sdbs_pkg;

    // Frame geometry; the pixel address is taken modulo the frame size,
    // which must be a power of two no larger than the address port allows.
    localparam int FRAME_PIXELS = 65536;
    localparam int ADDR_W       = $clog2(FRAME_PIXELS);
    localparam int IN_ADDR_W    = 16;

    localparam int PIX_W  = 8;
    localparam int GAIN_W = 4;
    localparam int VAR_W  = 8;
    localparam int PROD_W = GAIN_W + PIX_W;
    localparam int STATE_W = PIX_W + VAR_W;

    // Queue depths (powers of two)
    localparam int IQ_DEPTH = 4;
    localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
    localparam int IQ_CNT_W = $clog2(IQ_DEPTH + 1);
    localparam int OQ_DEPTH = 2;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VMIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VMAX = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RST = 4'd2;
    localparam logic [VAR_W-1:0]  VMIN_RST = 8'd1;
    localparam logic [VAR_W-1:0]  VMAX_RST = 8'd254;

    typedef enum logic {
        OP_INIT   = 1'b0,
        OP_UPDATE = 1'b1
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
    } t_item;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [VAR_W-1:0]  vmin;
        logic [VAR_W-1:0]  vmax;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] diff;
        logic             motion;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/sdbs_ram.sv -----
// ============================================================================
// sdbs_ram: simple dual-port RAM
// One write port and one read port with registered read data; a read at the
// address being written returns the old contents.
// ============================================================================
`default_nettype none

module sdbs_ram #(
    parameter int DEPTH  = 65536,
    parameter int DATA_W = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sdbs_front.sv -----
// ============================================================================
// sdbs_front: input side of the pixel pipeline
// Decodes the opcode, folds the address into the frame and holds items in a
// short queue until the back end takes them.
// ============================================================================
`default_nettype none

module sdbs_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    output logic                                o_full,
    input  wire logic                           i_opcode,
    input  wire logic [sdbs_pkg::IN_ADDR_W-1:0] i_pixel_address,
    input  wire logic [sdbs_pkg::PIX_W-1:0]     i_pixel_value,
    output logic                                o_valid,
    output sdbs_pkg::t_item                     o_item,
    input  wire logic                           i_take
);

    sdbs_pkg::t_item                     r_q [sdbs_pkg::IQ_DEPTH];
    logic [sdbs_pkg::IQ_PTR_W-1:0]       r_wptr, r_rptr;
    logic [sdbs_pkg::IQ_CNT_W-1:0]       r_cnt;
    sdbs_pkg::t_item                     w_item;
    logic                                w_wr, w_rd;

    always_comb begin
        w_item.op   = i_opcode ? sdbs_pkg::OP_UPDATE : sdbs_pkg::OP_INIT;
        w_item.addr = i_pixel_address[sdbs_pkg::ADDR_W-1:0];
        w_item.pix  = i_pixel_value;
    end

    assign o_full  = (r_cnt == sdbs_pkg::IQ_CNT_W'(sdbs_pkg::IQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sdbs_back.sv -----
// ============================================================================
// sdbs_back: per-pixel state update
// Reads the stored mean and variance, steps both, writes them back and queues
// the difference and motion flag; forwards state between back-to-back items.
// ============================================================================
`default_nettype none

module sdbs_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire sdbs_pkg::t_cfg             i_cfg,
    input  wire logic                       i_valid,
    input  wire sdbs_pkg::t_item            i_item,
    output logic                            o_take,
    output logic                            o_empty,
    output sdbs_pkg::t_result               o_result,
    input  wire logic                       i_pop
);

    // Stage 1: item whose state read is in flight
    logic                               r_s1_valid;
    sdbs_pkg::t_item                    r_s1_item;
    logic                               r_s1_hit;
    logic [sdbs_pkg::PIX_W-1:0]         r_byp_mean;
    logic [sdbs_pkg::VAR_W-1:0]         r_byp_var;

    logic [sdbs_pkg::STATE_W-1:0]       w_rdata;
    logic                               w_adv, w_fire, w_oq_full;

    logic [sdbs_pkg::PIX_W-1:0]         w_cur_mean, w_step_mean, w_mean, w_diff;
    logic [sdbs_pkg::VAR_W-1:0]         w_cur_var, w_clamp_hi, w_var;
    logic [sdbs_pkg::PROD_W-1:0]        w_prod, w_cur_var_x;
    logic [sdbs_pkg::VAR_W:0]           w_var_step;
    logic                               w_motion;

    // Output queue
    sdbs_pkg::t_result                  r_oq [sdbs_pkg::OQ_DEPTH];
    logic [sdbs_pkg::OQ_PTR_W-1:0]      r_owptr, r_orptr;
    logic [sdbs_pkg::OQ_CNT_W-1:0]      r_ocnt;
    logic                               w_opop;
    sdbs_pkg::t_result                  w_res;

    assign w_oq_full = (r_ocnt == sdbs_pkg::OQ_CNT_W'(sdbs_pkg::OQ_DEPTH));
    assign w_adv     = !r_s1_valid || !w_oq_full;
    assign w_fire    = r_s1_valid && !w_oq_full;
    assign o_take    = i_valid && w_adv;

    sdbs_ram #(
        .DEPTH  (sdbs_pkg::FRAME_PIXELS),
        .DATA_W (sdbs_pkg::STATE_W)
    ) u_state (
        .i_clk   (i_clk),
        .i_we    (w_fire),
        .i_waddr (r_s1_item.addr),
        .i_wdata ({w_mean, w_var}),
        .i_re    (o_take),
        .i_raddr (i_item.addr),
        .o_rdata (w_rdata)
    );

    // Pick stored or just-written state
    always_comb begin
        w_cur_mean = r_s1_hit ? r_byp_mean : w_rdata[sdbs_pkg::STATE_W-1:sdbs_pkg::VAR_W];
        w_cur_var  = r_s1_hit ? r_byp_var  : w_rdata[sdbs_pkg::VAR_W-1:0];

        if (w_cur_mean < r_s1_item.pix) begin
            w_step_mean = w_cur_mean + 1'b1;
        end else if (w_cur_mean > r_s1_item.pix) begin
            w_step_mean = w_cur_mean - 1'b1;
        end else begin
            w_step_mean = w_cur_mean;
        end

        w_diff = (w_step_mean > r_s1_item.pix) ? (w_step_mean - r_s1_item.pix)
                                               : (r_s1_item.pix - w_step_mean);
        w_prod      = sdbs_pkg::PROD_W'(i_cfg.gain) * sdbs_pkg::PROD_W'(w_diff);
        w_cur_var_x = sdbs_pkg::PROD_W'(w_cur_var);

        if (w_cur_var_x < w_prod) begin
            w_var_step = {1'b0, w_cur_var} + 1'b1;
        end else if (w_cur_var_x > w_prod) begin
            w_var_step = {1'b0, w_cur_var} - 1'b1;
        end else begin
            w_var_step = {1'b0, w_cur_var};
        end

        // Upper bound first, then lower bound
        w_clamp_hi = (w_var_step > {1'b0, i_cfg.vmax}) ? i_cfg.vmax
                                                        : w_var_step[sdbs_pkg::VAR_W-1:0];

        if (r_s1_item.op == sdbs_pkg::OP_INIT) begin
            w_mean = r_s1_item.pix;
            w_diff = '0;
            w_var  = i_cfg.vmin;
        end else begin
            w_mean = w_step_mean;
            w_var  = (w_clamp_hi < i_cfg.vmin) ? i_cfg.vmin : w_clamp_hi;
        end

        w_motion    = (w_diff >= w_var);
        w_res.diff   = w_diff;
        w_res.motion = w_motion;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_take) begin
            r_s1_valid <= 1'b1;
        end else if (w_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Capture item and forward state when its read overlapped the prior write
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_s1_item  <= i_item;
            r_s1_hit   <= w_fire && (r_s1_item.addr == i_item.addr);
            r_byp_mean <= w_mean;
            r_byp_var  <= w_var;
        end
    end

    assign w_opop   = i_pop && !o_empty;
    assign o_empty  = (r_ocnt == '0);
    assign o_result = r_oq[r_orptr];

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_oq[r_owptr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owptr <= '0;
            r_orptr <= '0;
            r_ocnt  <= '0;
        end else begin
            if (w_fire) begin
                r_owptr <= r_owptr + 1'b1;
            end
            if (w_opop) begin
                r_orptr <= r_orptr + 1'b1;
            end
            case ({w_fire, w_opop})
                2'b10:   r_ocnt <= r_ocnt + 1'b1;
                2'b01:   r_ocnt <= r_ocnt - 1'b1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sigma_delta_background_subtraction_top.sv -----
// ============================================================================
// sigma_delta_background_subtraction_top: Sigma-Delta motion detector
// Keeps a background mean and variance per pixel and flags each incoming
// pixel as foreground when its distance to the mean reaches the variance.
// ============================================================================
//
// Channel   Handshake          Payload
// -------   ----------------   ----------------------------------------------
// input     push / full        i_opcode, i_pixel_address, i_pixel_value
// result    empty / pop        o_abs_difference, o_motion_flag
// config    i_cfg_we           i_cfg_index (0 gain, 1 vmin, 2 vmax), i_cfg_data
//
// Sustained rate is one pixel beat per clock in and out while results are
// popped. A beat pushed into an empty block passes through the input queue,
// the state RAM read, and the update and write into the result queue before
// it shows up on the result side. The single-port-per-direction state RAM
// sets the rate: one read and one write each cycle. Reset is synchronous and
// active low; it clears queues and control and loads the register defaults,
// while the state RAM keeps its contents (entries are valid once an init
// beat has written them, and no clearing pass runs). A full result queue
// stalls the update stage, which then holds the input queue until it fills
// and raises full.
//
`default_nettype none

module sigma_delta_background_subtraction_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,

    input  wire logic                            push,
    output logic                                 full,
    input  wire logic                            i_opcode,
    input  wire logic [sdbs_pkg::IN_ADDR_W-1:0]  i_pixel_address,
    input  wire logic [sdbs_pkg::PIX_W-1:0]      i_pixel_value,

    output logic                                 empty,
    input  wire logic                            pop,
    output logic      [sdbs_pkg::PIX_W-1:0]      o_abs_difference,
    output logic                                 o_motion_flag,

    input  wire logic                            i_cfg_we,
    input  wire logic [sdbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sdbs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    sdbs_pkg::t_cfg    r_cfg;
    sdbs_pkg::t_item   w_item;
    sdbs_pkg::t_result w_result;
    logic              w_item_valid, w_take;

    // Configuration registers; write them only while the pipe is idle, since
    // a write applies to whatever beat is updated after the edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain <= sdbs_pkg::GAIN_RST;
            r_cfg.vmin <= sdbs_pkg::VMIN_RST;
            r_cfg.vmax <= sdbs_pkg::VMAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sdbs_pkg::CFG_GAIN: r_cfg.gain <= i_cfg_data[sdbs_pkg::GAIN_W-1:0];
                sdbs_pkg::CFG_VMIN: r_cfg.vmin <= i_cfg_data[sdbs_pkg::VAR_W-1:0];
                sdbs_pkg::CFG_VMAX: r_cfg.vmax <= i_cfg_data[sdbs_pkg::VAR_W-1:0];
                default:            r_cfg      <= r_cfg;  // unused index: drop
            endcase
        end
    end

    // Front: decode and queue incoming beats
    sdbs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_opcode        (i_opcode),
        .i_pixel_address (i_pixel_address),
        .i_pixel_value   (i_pixel_value),
        .o_valid         (w_item_valid),
        .o_item          (w_item),
        .i_take          (w_take)
    );

    // Back: read-modify-write of per-pixel state, result queue
    sdbs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (w_item_valid),
        .i_item   (w_item),
        .o_take   (w_take),
        .o_empty  (empty),
        .o_result (w_result),
        .i_pop    (pop)
    );

    assign o_abs_difference = w_result.diff;
    assign o_motion_flag    = w_result.motion;

endmodule

`default_nettype wire

// ----- rtl/core/sdbs_checker.sv -----
// ============================================================================
// sdbs_checker: port-level checks for the background subtraction block
// Watches queue flags and result stability on the top-level ports.
// ============================================================================
`default_nettype none

module sdbs_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       push,
    input wire logic                       full,
    input wire logic                       empty,
    input wire logic                       pop,
    input wire logic [sdbs_pkg::PIX_W-1:0] o_abs_difference,
    input wire logic                       o_motion_flag
);

    // Reset leaves both queues empty
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // Full can only rise after an accepted beat
    a_full_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && !full) |=> !$rose(full))
        else $error("full rose without an accepted beat");

    // A waiting result holds until popped
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_abs_difference)
                              && $stable(o_motion_flag)))
        else $error("waiting result changed or vanished");

endmodule

bind sigma_delta_background_subtraction_top sdbs_checker u_sdbs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .push             (push),
    .full             (full),
    .empty            (empty),
    .pop              (pop),
    .o_abs_difference (o_abs_difference),
    .o_motion_flag    (o_motion_flag)
);

`default_nettype wire
